// ----- rtl/core/i2c_register_access_master_defines.svh -----
// Assertion macros used by the checker file of the I2C register access master.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CRA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/i2cra_pkg.sv -----
// Shared types, constants and field positions of the I2C register access master.
// Used by the sequencer, top level and checker through scoped names; depends on nothing.
`timescale 1ns / 1ps

package i2cra_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int BCNT_W = (QFILL_W > 5) ? QFILL_W : 5;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd30;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd251;
	localparam logic [7:0] DEV_ADDR_RST = 8'hD0;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_DEV_ADDR = 2'd2;

	// Input stream field positions.
	localparam int IN_TDATA_W = 24;
	localparam int IB_REG_LSB = 0;
	localparam int IB_CNT_LSB = 8;
	localparam int IB_WB_LSB = 13;
	localparam int IB_SDA = 21;

	// Output stream field positions.
	localparam int OUT_TDATA_W = 16;
	localparam int OB_SCL = 0;
	localparam int OB_SDA_OUT = 1;
	localparam int OB_SDA_EN = 2;
	localparam int OB_BUSY = 3;
	localparam int OB_VALID = 4;
	localparam int OB_DATA_LSB = 5;
	localparam int OB_DONE = 13;
	localparam int OB_ERROR = 14;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_QUEUE = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_RS_PRE = 4'd1,
		ST_S_HI   = 4'd2,
		ST_S_LO   = 4'd3,
		ST_W_LO   = 4'd4,
		ST_W_HI   = 4'd5,
		ST_A_LO   = 4'd6,
		ST_A_HI   = 4'd7,
		ST_A_POLL = 4'd8,
		ST_R_LO   = 4'd9,
		ST_R_HI   = 4'd10,
		ST_M_LO   = 4'd11,
		ST_M_HI   = 4'd12,
		ST_T_LO   = 4'd13,
		ST_T_MID  = 4'd14,
		ST_T_HI   = 4'd15
	} seq_state_t;

	typedef enum logic [1:0] {
		STG_ADDR  = 2'd0,
		STG_REG   = 2'd1,
		STG_RADDR = 2'd2,
		STG_DATA  = 2'd3
	} stage_t;

	typedef struct packed {
		logic [15:0] half_period;
		logic [7:0]  ack_timeout;
		logic [7:0]  device_address;
	} cfg_t;

	typedef struct packed {
		logic               we;
		logic [QADDR_W-1:0] addr;
		logic [7:0]         data;
	} qwr_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_out;
		logic       sda_enable;
		logic       busy;
		logic       read_valid;
		logic [7:0] read_data;
		logic       read_last;
		logic       done;
		logic       error;
	} res_t;

endpackage

// ----- rtl/core/i2cra_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; holds the write byte queue of the I2C master.
`timescale 1ns / 1ps

module i2cra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/i2cra_seq.sv -----
// Bit-level transaction sequencer of the I2C master: phase timing, shifting,
// ack polling and queue pointers. Depends on i2cra_pkg; the queue RAM sits outside.
`timescale 1ns / 1ps

module i2cra_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  i2cra_pkg::op_t                operation,
	input  logic [7:0]                    register_address,
	input  logic [4:0]                    byte_count,
	input  logic [7:0]                    write_byte,
	input  logic                          sda_in,
	input  i2cra_pkg::cfg_t               cfg,
	input  logic [7:0]                    q_rdata,
	output logic [i2cra_pkg::QADDR_W-1:0] q_raddr,
	output i2cra_pkg::qwr_t               q_wr,
	output i2cra_pkg::res_t               res
);

	i2cra_pkg::seq_state_t state_q, state_d;
	i2cra_pkg::stage_t     stage_q, stage_d;
	logic [15:0]                   phase_q, phase_d;
	logic [3:0]                    bit_q, bit_d;
	logic [7:0]                    shift_q, shift_d;
	logic [i2cra_pkg::BCNT_W-1:0]  bcnt_q, bcnt_d;
	logic [7:0]                    ackc_q, ackc_d;
	logic [i2cra_pkg::QFILL_W-1:0] fill_q, fill_d;
	logic [7:0]                    lreg_q, lreg_d;
	logic                          is_read_q, is_read_d;
	logic                          err_q, err_d;

	logic       ev_valid, ev_last, ev_done, ev_error;
	logic [7:0] ev_data;
	logic       more_data;
	logic       phase_end;
	logic       ack_expired;

	// The queue read port always follows the byte pointer; the pointer is stable
	// for several items before the ack poll that consumes the data.
	assign q_raddr = bcnt_q[i2cra_pkg::QADDR_W-1:0];

	assign more_data = (bcnt_q < i2cra_pkg::BCNT_W'(fill_q)) &&
		(bcnt_q < i2cra_pkg::BCNT_W'(i2cra_pkg::QUEUE_DEPTH));
	assign phase_end = ({1'b0, phase_q} + 17'd1) >= {1'b0, cfg.half_period};
	assign ack_expired = ({1'b0, ackc_q} + 9'd1) >= {1'b0, cfg.ack_timeout};

	// Next-state logic.
	always_comb begin
		logic [i2cra_pkg::BCNT_W-1:0] bc_dec;
		bc_dec = (bcnt_q != '0) ? bcnt_q - 1'b1 : '0;
		state_d = state_q;
		stage_d = stage_q;
		phase_d = phase_q;
		bit_d = bit_q;
		shift_d = shift_q;
		bcnt_d = bcnt_q;
		ackc_d = ackc_q;
		fill_d = fill_q;
		lreg_d = lreg_q;
		is_read_d = is_read_q;
		err_d = err_q;
		ev_valid = 1'b0;
		ev_data = 8'd0;
		ev_last = 1'b0;
		ev_done = 1'b0;
		ev_error = 1'b0;
		q_wr = '0;
		if (state_q == i2cra_pkg::ST_IDLE) begin
			if (operation == i2cra_pkg::OP_QUEUE) begin
				if (fill_q < i2cra_pkg::QFILL_W'(i2cra_pkg::QUEUE_DEPTH)) begin
					q_wr.we = 1'b1;
					q_wr.addr = fill_q[i2cra_pkg::QADDR_W-1:0];
					q_wr.data = write_byte;
					fill_d = fill_q + 1'b1;
				end
			end else if (operation == i2cra_pkg::OP_READ ||
				operation == i2cra_pkg::OP_WRITE) begin
				is_read_d = (operation == i2cra_pkg::OP_READ);
				lreg_d = register_address;
				bcnt_d = (operation == i2cra_pkg::OP_READ) ?
					i2cra_pkg::BCNT_W'(byte_count) : '0;
				stage_d = i2cra_pkg::STG_ADDR;
				err_d = 1'b0;
				phase_d = 16'd0;
				state_d = i2cra_pkg::ST_S_HI;
			end
		end else if (state_q == i2cra_pkg::ST_A_POLL) begin
			phase_d = 16'd0;
			if (!sda_in) begin
				case (stage_q)
					i2cra_pkg::STG_ADDR: begin
						stage_d = i2cra_pkg::STG_REG;
						shift_d = lreg_q;
						bit_d = 4'd0;
						state_d = i2cra_pkg::ST_W_LO;
					end
					i2cra_pkg::STG_RADDR: begin
						if (bcnt_q == '0) begin
							state_d = i2cra_pkg::ST_T_LO;
						end else begin
							shift_d = 8'd0;
							bit_d = 4'd0;
							state_d = i2cra_pkg::ST_R_LO;
						end
					end
					default: begin
						if (stage_q == i2cra_pkg::STG_REG && is_read_q) begin
							stage_d = i2cra_pkg::STG_RADDR;
							state_d = i2cra_pkg::ST_RS_PRE;
						end else begin
							stage_d = i2cra_pkg::STG_DATA;
							if (more_data) begin
								shift_d = q_rdata;
								bit_d = 4'd0;
								bcnt_d = bcnt_q + 1'b1;
								state_d = i2cra_pkg::ST_W_LO;
							end else begin
								state_d = i2cra_pkg::ST_T_LO;
							end
						end
					end
				endcase
			end else if (ack_expired) begin
				err_d = 1'b1;
				state_d = i2cra_pkg::ST_T_LO;
			end else begin
				ackc_d = ackc_q + 8'd1;
			end
		end else if (phase_end) begin
			phase_d = 16'd0;
			case (state_q)
				i2cra_pkg::ST_RS_PRE: state_d = i2cra_pkg::ST_S_HI;
				i2cra_pkg::ST_S_HI:   state_d = i2cra_pkg::ST_S_LO;
				i2cra_pkg::ST_S_LO: begin
					shift_d = (stage_q == i2cra_pkg::STG_RADDR) ?
						cfg.device_address + 8'd1 : cfg.device_address;
					bit_d = 4'd0;
					state_d = i2cra_pkg::ST_W_LO;
				end
				i2cra_pkg::ST_W_LO: state_d = i2cra_pkg::ST_W_HI;
				i2cra_pkg::ST_W_HI: begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d = bit_q + 4'd1;
					if (bit_q >= 4'd7) begin
						ackc_d = 8'd0;
						state_d = i2cra_pkg::ST_A_LO;
					end else begin
						state_d = i2cra_pkg::ST_W_LO;
					end
				end
				i2cra_pkg::ST_A_LO: state_d = i2cra_pkg::ST_A_HI;
				i2cra_pkg::ST_A_HI: state_d = i2cra_pkg::ST_A_POLL;
				i2cra_pkg::ST_R_LO: state_d = i2cra_pkg::ST_R_HI;
				i2cra_pkg::ST_R_HI: begin
					shift_d = {shift_q[6:0], sda_in};
					bit_d = bit_q + 4'd1;
					if (bit_q >= 4'd7) begin
						ev_valid = 1'b1;
						ev_data = {shift_q[6:0], sda_in};
						ev_last = (bcnt_q == i2cra_pkg::BCNT_W'(1));
						state_d = i2cra_pkg::ST_M_LO;
					end else begin
						state_d = i2cra_pkg::ST_R_LO;
					end
				end
				i2cra_pkg::ST_M_LO: state_d = i2cra_pkg::ST_M_HI;
				i2cra_pkg::ST_M_HI: begin
					bcnt_d = bc_dec;
					if (bc_dec == '0) begin
						state_d = i2cra_pkg::ST_T_LO;
					end else begin
						shift_d = 8'd0;
						bit_d = 4'd0;
						state_d = i2cra_pkg::ST_R_LO;
					end
				end
				i2cra_pkg::ST_T_LO:  state_d = i2cra_pkg::ST_T_MID;
				i2cra_pkg::ST_T_MID: state_d = i2cra_pkg::ST_T_HI;
				i2cra_pkg::ST_T_HI: begin
					ev_done = 1'b1;
					ev_error = err_q;
					err_d = 1'b0;
					// A write consumes the queue; a read leaves it for later.
					if (!is_read_q) begin
						fill_d = '0;
					end
					bcnt_d = '0;
					state_d = i2cra_pkg::ST_IDLE;
				end
				default: state_d = i2cra_pkg::ST_IDLE;
			endcase
		end else begin
			phase_d = phase_q + 16'd1;
		end
	end

	// Output logic: the bus levels shown are those of the state after the update.
	always_comb begin
		res = '0;
		res.scl_level = 1'b1;
		res.sda_out = 1'b1;
		res.sda_enable = 1'b0;
		res.busy = (state_d != i2cra_pkg::ST_IDLE);
		res.read_valid = ev_valid;
		res.read_data = ev_data;
		res.read_last = ev_last;
		res.done = ev_done;
		res.error = ev_error;
		case (state_d)
			i2cra_pkg::ST_RS_PRE: begin
				res.scl_level = 1'b0;
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_S_HI: begin
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_S_LO: begin
				res.sda_out = 1'b0;
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_W_LO: begin
				res.scl_level = 1'b0;
				res.sda_out = shift_d[7];
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_W_HI: begin
				res.sda_out = shift_d[7];
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_A_LO, i2cra_pkg::ST_R_LO: begin
				res.scl_level = 1'b0;
			end
			i2cra_pkg::ST_M_LO: begin
				res.scl_level = 1'b0;
				res.sda_out = (bcnt_d == i2cra_pkg::BCNT_W'(1));
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_M_HI: begin
				res.sda_out = (bcnt_d == i2cra_pkg::BCNT_W'(1));
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_T_LO: begin
				res.scl_level = 1'b0;
				res.sda_out = 1'b0;
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_T_MID: begin
				res.sda_out = 1'b0;
				res.sda_enable = 1'b1;
			end
			i2cra_pkg::ST_T_HI: begin
				res.sda_enable = 1'b1;
			end
			default: begin
				res.scl_level = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cra_pkg::ST_IDLE;
			stage_q <= i2cra_pkg::STG_ADDR;
			phase_q <= 16'd0;
			bit_q <= 4'd0;
			shift_q <= 8'd0;
			bcnt_q <= '0;
			ackc_q <= 8'd0;
			fill_q <= '0;
			lreg_q <= 8'd0;
			is_read_q <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			stage_q <= stage_d;
			phase_q <= phase_d;
			bit_q <= bit_d;
			shift_q <= shift_d;
			bcnt_q <= bcnt_d;
			ackc_q <= ackc_d;
			fill_q <= fill_d;
			lreg_q <= lreg_d;
			is_read_q <= is_read_d;
			err_q <= err_d;
		end
	end

endmodule

// ----- rtl/core/i2c_register_access_master.sv -----
// Tick-driven I2C register read/write master. Each input transfer is one timing tick and
// yields one result transfer in the next cycle; one tick is accepted every cycle while the
// output register is empty or being drained, so throughput is one item per cycle.
// The write queue lives in a RAM with a registered read port, addressed by the byte
// pointer. Reset (arst_n, async) idles the bus, empties the queue by its fill count without
// a clearing pass, and loads half_period 30, ack_timeout 251, device_address 0xD0.
`timescale 1ns / 1ps

module i2c_register_access_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// register_address[7:0], byte_count[12:8], write_byte[20:13], sda_in[21], zero[23:22]
	input  logic [23:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_out[1], sda_enable[2], busy_res[3], read_valid[4],
	// read_data[12:5], done_res[13], error[14], zero[15]
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	i2cra_pkg::cfg_t cfg_q;
	i2cra_pkg::qwr_t q_wr;
	i2cra_pkg::res_t res;
	i2cra_pkg::res_t res_q;
	logic [i2cra_pkg::QADDR_W-1:0] q_raddr;
	logic [7:0] q_rdata;
	logic       m_valid_q;
	logic       accept;

	assign s_tready = !m_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= i2cra_pkg::HALF_PERIOD_RST;
			cfg_q.ack_timeout <= i2cra_pkg::ACK_TIMEOUT_RST;
			cfg_q.device_address <= i2cra_pkg::DEV_ADDR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cra_pkg::CFG_HALF_PERIOD: cfg_q.half_period <= cfg_data;
				i2cra_pkg::CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data[7:0];
				i2cra_pkg::CFG_DEV_ADDR:    cfg_q.device_address <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	i2cra_ram #(
		.WIDTH(8),
		.DEPTH(i2cra_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (q_wr.we && accept),
		.waddr(q_wr.addr),
		.wdata(q_wr.data),
		.raddr(q_raddr),
		.rdata(q_rdata)
	);

	i2cra_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.operation       (i2cra_pkg::op_t'(s_tuser)),
		.register_address(s_tdata[i2cra_pkg::IB_REG_LSB +: 8]),
		.byte_count      (s_tdata[i2cra_pkg::IB_CNT_LSB +: 5]),
		.write_byte      (s_tdata[i2cra_pkg::IB_WB_LSB +: 8]),
		.sda_in          (s_tdata[i2cra_pkg::IB_SDA]),
		.cfg             (cfg_q),
		.q_rdata         (q_rdata),
		.q_raddr         (q_raddr),
		.q_wr            (q_wr),
		.res             (res)
	);

	// Output register: holds one result while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[i2cra_pkg::OB_SCL] = res_q.scl_level;
		m_tdata[i2cra_pkg::OB_SDA_OUT] = res_q.sda_out;
		m_tdata[i2cra_pkg::OB_SDA_EN] = res_q.sda_enable;
		m_tdata[i2cra_pkg::OB_BUSY] = res_q.busy;
		m_tdata[i2cra_pkg::OB_VALID] = res_q.read_valid;
		m_tdata[i2cra_pkg::OB_DATA_LSB +: 8] = res_q.read_data;
		m_tdata[i2cra_pkg::OB_DONE] = res_q.done;
		m_tdata[i2cra_pkg::OB_ERROR] = res_q.error;
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast = res_q.read_last;

endmodule

// ----- rtl/core/i2cra_checker.sv -----
// Port-level checks of the I2C register access master, bound to the top level.
// Depends on i2cra_pkg and the assertion macros in i2c_register_access_master_defines.svh.
`timescale 1ns / 1ps
`include "i2c_register_access_master_defines.svh"

module i2cra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [15:0] cfg_data
);

	`I2CRA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`I2CRA_ASSERT_SAME(a_err_done, m_tvalid && m_tdata[i2cra_pkg::OB_ERROR], m_tdata[i2cra_pkg::OB_DONE], "error without done")
	`I2CRA_ASSERT_SAME(a_last_valid, m_tvalid && m_tlast, m_tdata[i2cra_pkg::OB_VALID], "read_last without read byte")
	`I2CRA_ASSERT_SAME(a_idle_bus, m_tvalid && !m_tdata[i2cra_pkg::OB_BUSY], m_tdata[i2cra_pkg::OB_SCL] && m_tdata[i2cra_pkg::OB_SDA_OUT] && !m_tdata[i2cra_pkg::OB_SDA_EN], "idle bus not released")

endmodule

bind i2c_register_access_master i2cra_checker u_i2cra_checker (.*);
